>>> rtl/core/longest_palindromic_substring_defines.svh
// Assertion macros for the longest palindromic substring checker.
`ifndef LONGEST_PALINDROMIC_SUBSTRING_DEFINES_SVH
`define LONGEST_PALINDROMIC_SUBSTRING_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lps_pkg.sv
// Shared constants and the control bundle that travels along the cell chain.
package lps_pkg;

  localparam int unsigned MaxLenDefault = 1024;
  localparam int unsigned ChrW          = 8;
  localparam int unsigned StartWDefault = $clog2(MaxLenDefault);
  localparam int unsigned LenWDefault   = $clog2(MaxLenDefault + 1);

  // Control bits of one item as it moves from cell to cell.
  typedef struct packed {
    logic vld;       // slot holds an item
    logic act;       // item falls inside the string limit and updates cells
    logic last;      // item closes the string
    logic ovf;       // string has dropped bytes so far
    logic up_flag;   // flag of the cell above, as it stood before this item
    logic cand_vld;  // some cell above has matched for this item
  } lps_ctrl_t;

endpackage

>>> rtl/core/lps_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
interface lps_in_if;
  import lps_pkg::*;

  logic            valid;
  logic            ready;
  logic [ChrW-1:0] character;
  logic            last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface lps_out_if #(
  parameter int unsigned StartW = lps_pkg::StartWDefault,
  parameter int unsigned LenW   = lps_pkg::LenWDefault
);
  logic              valid;
  logic              ready;
  logic [StartW-1:0] start_res;
  logic [LenW-1:0]   length;
  logic              overflow;

  modport source (output valid, output start_res, output length, output overflow,
                  input ready);
  modport sink   (input valid, input start_res, input length, input overflow,
                  output ready);
endinterface

>>> rtl/core/longest_palindromic_substring.sv
// The closing item passes the MaxLen cell registers, then the result register.
// Throughput: one byte per cycle unless stalled; each item walks all MaxLen cells.
// The chain stalls only while a finished result waits and another string closes.
// Reset (async, active low) clears the pipeline valid bits, the flags and the string
// counters; stored bytes need no clear, each string rewrites the entries it reads.
module longest_palindromic_substring #(
  parameter int unsigned MaxLen = lps_pkg::MaxLenDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lps_in_if.sink    in_i,
  lps_out_if.source out_o
);
  import lps_pkg::*;

  localparam int unsigned IW = $clog2(MaxLen);
  localparam int unsigned LW = $clog2(MaxLen + 1);

  // Chain layout: link[MaxLen] is the entry, cell k reads link[k+1] and drives
  // link[k], link[0] feeds the tail. Items enter at the top cell (highest start
  // index) and move down one cell per cycle unless stalled. Each cell compares
  // its stored byte with the item's byte and hands its flag, as it stood before
  // this item, to the cell below, which needs exactly that value when the item
  // reaches it. The lowest matching start overwrites the candidate on the way
  // down, so the tail sees the longest span ending at the item's position.
  lps_ctrl_t       link_ctrl [MaxLen+1];
  logic [ChrW-1:0] link_chr  [MaxLen+1];
  logic [IW-1:0]   link_pos  [MaxLen+1];
  logic [IW-1:0]   link_cand [MaxLen+1];

  logic          adv;
  logic [LW-1:0] pos_q;
  logic          ovf_q;
  logic          in_full;
  logic          acc;

  // Position of the next byte within the string; it saturates at MaxLen, and
  // further bytes travel as inactive items that only carry the overflow mark.
  assign in_full   = (pos_q == LW'(MaxLen));
  assign in_i.ready = adv;
  assign acc       = in_i.valid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else if (acc) begin
      if (in_i.last) begin
        // close the string: start counting again for the next one
        pos_q <= '0;
        ovf_q <= 1'b0;
      end else if (in_full) begin
        ovf_q <= 1'b1;
      end else begin
        pos_q <= pos_q + LW'(1);
      end
    end
  end

  assign link_ctrl[MaxLen] = '{vld: in_i.valid, act: !in_full, last: in_i.last,
                               ovf: ovf_q || in_full, up_flag: 1'b0, cand_vld: 1'b0};
  assign link_chr[MaxLen]  = in_i.character;
  assign link_pos[MaxLen]  = pos_q[IW-1:0];
  assign link_cand[MaxLen] = '0;

  for (genvar k = 0; k < MaxLen; k++) begin : g_cell
    lps_cell #(
      .MaxLen (MaxLen),
      .Idx    (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctrl_i (link_ctrl[k+1]),
      .chr_i  (link_chr[k+1]),
      .pos_i  (link_pos[k+1]),
      .cand_i (link_cand[k+1]),
      .ctrl_o (link_ctrl[k]),
      .chr_o  (link_chr[k]),
      .pos_o  (link_pos[k]),
      .cand_o (link_cand[k])
    );
  end

  // Tail: keep the best span of the open string, emit it on the closing item.
  lps_collect #(
    .MaxLen (MaxLen)
  ) u_collect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (link_ctrl[0]),
    .pos_i  (link_pos[0]),
    .cand_i (link_cand[0]),
    .adv_o  (adv),
    .out_o  (out_o)
  );

endmodule

>>> rtl/core/lps_cell.sv
// One chain cell: a stored byte and its palindrome flag for one start index.
module lps_cell #(
  parameter int unsigned MaxLen = lps_pkg::MaxLenDefault,
  parameter int unsigned Idx    = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  lps_pkg::lps_ctrl_t            ctrl_i,
  input  logic [lps_pkg::ChrW-1:0]      chr_i,
  input  logic [$clog2(MaxLen)-1:0]     pos_i,
  input  logic [$clog2(MaxLen)-1:0]     cand_i,
  output lps_pkg::lps_ctrl_t            ctrl_o,
  output logic [lps_pkg::ChrW-1:0]      chr_o,
  output logic [$clog2(MaxLen)-1:0]     pos_o,
  output logic [$clog2(MaxLen)-1:0]     cand_o
);
  import lps_pkg::*;

  localparam int unsigned IW = $clog2(MaxLen);
  localparam logic [IW-1:0] MyIdx = IW'(Idx);

  logic [ChrW-1:0] byte_q;
  logic            flag_q;
  lps_ctrl_t       ctrl_q, ctrl_d;
  logic [ChrW-1:0] chr_q;
  logic [IW-1:0]   pos_q;
  logic [IW-1:0]   cand_q, cand_d;
  logic            work, below, here, near, hit;

  always_comb begin
    work  = adv_i && ctrl_i.vld && ctrl_i.act;
    below = work && (MyIdx < pos_i);
    here  = work && (MyIdx == pos_i);
    near  = (pos_i - MyIdx) == IW'(1);
    hit   = below && (byte_q == chr_i) && (near || ctrl_i.up_flag);

    // pass the old flag down, mark a match, keep the lowest matching start
    ctrl_d          = ctrl_i;
    ctrl_d.up_flag  = flag_q;
    ctrl_d.cand_vld = ctrl_i.cand_vld | hit;
    cand_d          = hit ? MyIdx : cand_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      flag_q <= 1'b0;
    end else begin
      if (adv_i) begin
        ctrl_q <= ctrl_d;
      end
      if (below) begin
        flag_q <= hit;
      end else if (here) begin
        flag_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      chr_q  <= chr_i;
      pos_q  <= pos_i;
      cand_q <= cand_d;
    end
    if (here) begin
      byte_q <= chr_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign chr_o  = chr_q;
  assign pos_o  = pos_q;
  assign cand_o = cand_q;

endmodule

>>> rtl/core/lps_collect.sv
// Chain tail: track the best span per string and hold the result item.
module lps_collect #(
  parameter int unsigned MaxLen = lps_pkg::MaxLenDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lps_pkg::lps_ctrl_t        ctrl_i,
  input  logic [$clog2(MaxLen)-1:0] pos_i,
  input  logic [$clog2(MaxLen)-1:0] cand_i,
  output logic                      adv_o,
  lps_out_if.source                 out_o
);
  import lps_pkg::*;

  localparam int unsigned IW = $clog2(MaxLen);
  localparam int unsigned LW = $clog2(MaxLen + 1);

  logic [LW-1:0] best_len_q, best_len_d;
  logic [IW-1:0] best_start_q, best_start_d;
  logic [LW-1:0] len_hit;
  logic          take, upd;
  logic          res_vld_q;
  logic [IW-1:0] res_start_q;
  logic [LW-1:0] res_len_q;
  logic          res_ovf_q;

  // stall the chain only when a closing item meets a result not yet taken
  assign adv_o = !(ctrl_i.vld && ctrl_i.last && res_vld_q && !out_o.ready);
  assign take  = adv_o && ctrl_i.vld;

  always_comb begin
    len_hit      = LW'(pos_i) - LW'(cand_i) + LW'(1);
    upd          = ctrl_i.act && ctrl_i.cand_vld && (best_len_q < len_hit);
    best_len_d   = upd ? len_hit : best_len_q;
    best_start_d = upd ? cand_i  : best_start_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_len_q   <= '0;
      best_start_q <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      if (take) begin
        if (ctrl_i.last) begin
          best_len_q   <= '0;
          best_start_q <= '0;
        end else begin
          best_len_q   <= best_len_d;
          best_start_q <= best_start_d;
        end
      end
      if (take && ctrl_i.last) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ctrl_i.last) begin
      // no span longer than one byte: report start 0, length 1
      res_len_q   <= (best_len_d == '0) ? LW'(1) : best_len_d;
      res_start_q <= (best_len_d == '0) ? '0 : best_start_d;
      res_ovf_q   <= ctrl_i.ovf;
    end
  end

  assign out_o.valid     = res_vld_q;
  assign out_o.start_res = res_start_q;
  assign out_o.length    = res_len_q;
  assign out_o.overflow  = res_ovf_q;

endmodule

>>> rtl/core/lps_checker.sv
// Port-level checks for the longest palindromic substring block, with its bind.
`include "longest_palindromic_substring_defines.svh"

module lps_checker #(
  parameter int unsigned MaxLen = lps_pkg::MaxLenDefault
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [$clog2(MaxLen)-1:0]   start_res_i,
  input logic [$clog2(MaxLen+1)-1:0] length_i
);

  // a held result stays offered until taken
  `LPS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // input back-pressure only comes from a result waiting at the output
  `LPS_ASSERT_NOW(a_in_stall_cause, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without cause")

  // reported span is non-empty and fits the string limit
  `LPS_ASSERT_NOW(a_span_fits, out_valid_i, (length_i != '0) && ((32'(start_res_i) + 32'(length_i)) <= MaxLen), "span out of range")

  // a single-byte answer always sits at start 0
  `LPS_ASSERT_NOW(a_single_at_zero, out_valid_i && (start_res_i != '0), length_i > 1, "nonzero start with unit length")

endmodule

bind longest_palindromic_substring lps_checker #(
  .MaxLen (MaxLen)
) u_lps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .start_res_i (out_o.start_res),
  .length_i    (out_o.length)
);
